@@ sv/fvd_pkg.sv @@
// Shared types and constants for the face fan vertex dedup block.
// Used by fvd_ctrl, fvd_datapath and face_fan_vertex_dedup_core; no dependencies.
`default_nettype none

package fvd_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_REF_WIDTH   = 16;

    // Fixed widths of the result fields
    localparam int IDX_W = 8;
    localparam int VAL_W = 16;

    // Dedup search starts once the table holds this many entries
    localparam int DEDUP_MIN = 3;

    // Corner counter saturates here; from this corner on a fan triangle is emitted
    localparam logic [1:0] CORNER_FAN = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPEND,
        ST_FULL_RD,
        ST_FULL_LD,
        ST_EMIT_FIRST,
        ST_EMIT_LAST,
        ST_EMIT_CUR
    } fvd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic search;
        logic read_zero;
        logic load_match;
        logic load_new;
        logic load_full;
        logic emit_first;
        logic emit_last;
        logic emit_cur;
    } fvd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic match;
        logic scan_done;
        logic count_ge_min;
        logic count_full;
        logic fan_corner;
        logic out_free;
    } fvd_stat_t;

endpackage

`default_nettype wire

@@ sv/fvd_ctrl.sv @@
// Sequencer for the face fan vertex dedup block: search, append or full-table fallback, emit.
// Depends on fvd_pkg; drives fvd_datapath through fvd_cmd_t.
`default_nettype none

module fvd_ctrl
    import fvd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire fvd_stat_t stat,
    output fvd_cmd_t       cmd
);

    fvd_state_t state_reg;
    fvd_state_t state_next;
    fvd_state_t after_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign after_load = stat.fan_corner ? ST_EMIT_FIRST : ST_EMIT_CUR;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.count_ge_min ? ST_SEARCH : ST_APPEND;
                end
            end
            ST_SEARCH:
            begin
                priority if (stat.match)
                begin
                    state_next = after_load;
                end
                else if (stat.scan_done)
                begin
                    state_next = stat.count_full ? ST_FULL_RD : ST_APPEND;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_APPEND:     state_next = after_load;
            ST_FULL_RD:    state_next = ST_FULL_LD;
            ST_FULL_LD:    state_next = after_load;
            ST_EMIT_FIRST:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_EMIT_LAST;
                end
            end
            ST_EMIT_LAST:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_EMIT_CUR;
                end
            end
            ST_EMIT_CUR:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_SEARCH:
            begin
                cmd.search     = !stat.match;
                cmd.load_match = stat.match;
            end
            ST_APPEND:     cmd.load_new   = 1'b1;
            ST_FULL_RD:    cmd.read_zero  = 1'b1;
            ST_FULL_LD:    cmd.load_full  = 1'b1;
            ST_EMIT_FIRST: cmd.emit_first = stat.out_free;
            ST_EMIT_LAST:  cmd.emit_last  = stat.out_free;
            ST_EMIT_CUR:   cmd.emit_cur   = stat.out_free;
            default:       cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/fvd_datapath.sv @@
// Datapath of the face fan vertex dedup block: vertex table memory, scan
// pointer, fill count, fan registers and output register. Depends on fvd_pkg.
`default_nettype none

module fvd_datapath
    import fvd_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int REF_WIDTH   = DEF_REF_WIDTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [REF_WIDTH-1:0] pos_ref,
    input  wire logic [REF_WIDTH-1:0] tex_ref,
    input  wire logic [REF_WIDTH-1:0] norm_ref,
    input  wire logic                 face_start,
    input  wire fvd_cmd_t             cmd,
    output fvd_stat_t                 stat,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [IDX_W-1:0]          vertex_index,
    output logic                      is_new,
    output logic [VAL_W-1:0]          pos_value,
    output logic [VAL_W-1:0]          tex_value,
    output logic [VAL_W-1:0]          norm_value,
    output logic                      run_last,
    output logic                      table_full
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int EW = 3 * REF_WIDTH;

    logic [EW-1:0]        mem [TABLE_DEPTH];

    logic [REF_WIDTH-1:0] p_zb, t_zb, n_zb;
    logic [REF_WIDTH-1:0] p_reg, t_reg, n_reg;
    logic [1:0]           corner_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        scan_reg;
    logic                 scan_issue;
    logic [AW-1:0]        rd_addr;
    logic                 rd_valid_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [EW-1:0]        rd_data_reg;
    logic [REF_WIDTH-1:0] rd_pos, rd_tex, rd_norm;

    logic [IDX_W-1:0]     cur_idx_reg;
    logic [REF_WIDTH-1:0] cur_pos_reg, cur_tex_reg, cur_norm_reg;
    logic                 cur_new_reg, cur_full_reg;
    logic [IDX_W-1:0]     first_idx_reg, last_idx_reg;
    logic [REF_WIDTH-1:0] first_pos_reg, first_tex_reg, first_norm_reg;
    logic [REF_WIDTH-1:0] last_pos_reg, last_tex_reg, last_norm_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic [REF_WIDTH-1:0] out_pos_reg, out_pos_next;
    logic [REF_WIDTH-1:0] out_tex_reg, out_tex_next;
    logic [REF_WIDTH-1:0] out_norm_reg, out_norm_next;
    logic                 out_new_reg, out_new_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_full_reg, out_full_next;

    // One-based to zero-based; absent texture or normal maps to zero
    assign p_zb = pos_ref - REF_WIDTH'(1);
    assign t_zb = (tex_ref == '0) ? '0 : tex_ref - REF_WIDTH'(1);
    assign n_zb = (norm_ref == '0) ? '0 : norm_ref - REF_WIDTH'(1);

    assign scan_issue = cmd.search && (scan_reg != count_reg);
    assign rd_addr    = cmd.read_zero ? '0 : scan_reg[AW-1:0];

    assign rd_pos  = rd_data_reg[EW-1 -: REF_WIDTH];
    assign rd_tex  = rd_data_reg[2*REF_WIDTH-1 -: REF_WIDTH];
    assign rd_norm = rd_data_reg[REF_WIDTH-1:0];

    assign stat.match        = rd_valid_reg && (rd_pos == p_reg) && (rd_tex == t_reg);
    assign stat.scan_done    = (scan_reg == count_reg) && !rd_valid_reg;
    assign stat.count_ge_min = count_reg >= CW'(DEDUP_MIN);
    assign stat.count_full   = count_reg == CW'(TABLE_DEPTH);
    assign stat.fan_corner   = corner_reg == CORNER_FAN;
    assign stat.out_free     = !out_valid_reg || !out_stall;

    // Vertex table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_new)
        begin
            mem[count_reg[AW-1:0]] <= {p_reg, t_reg, n_reg};
        end
        if (scan_issue || cmd.read_zero)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (scan_issue)
        begin
            rd_idx_reg <= scan_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p_reg <= p_zb;
            t_reg <= t_zb;
            n_reg <= n_zb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            corner_reg    <= '0;
            first_idx_reg <= '0;
            last_idx_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= scan_issue;
            if (cmd.accept)
            begin
                scan_reg <= '0;
                if (face_start)
                begin
                    corner_reg <= '0;
                end
            end
            else if (scan_issue)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
            if (cmd.load_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.emit_cur)
            begin
                if (corner_reg == '0)
                begin
                    first_idx_reg <= cur_idx_reg;
                end
                last_idx_reg <= cur_idx_reg;
                if (corner_reg != CORNER_FAN)
                begin
                    corner_reg <= corner_reg + 2'd1;
                end
            end
        end
    end

    // Current corner's entry and cached fan entry values
    always_ff @(posedge clk)
    begin
        priority if (cmd.load_match)
        begin
            cur_idx_reg  <= IDX_W'(rd_idx_reg);
            cur_pos_reg  <= rd_pos;
            cur_tex_reg  <= rd_tex;
            cur_norm_reg <= rd_norm;
            cur_new_reg  <= 1'b0;
            cur_full_reg <= 1'b0;
        end
        else if (cmd.load_new)
        begin
            cur_idx_reg  <= IDX_W'(count_reg);
            cur_pos_reg  <= p_reg;
            cur_tex_reg  <= t_reg;
            cur_norm_reg <= n_reg;
            cur_new_reg  <= 1'b1;
            cur_full_reg <= 1'b0;
        end
        else if (cmd.load_full)
        begin
            cur_idx_reg  <= '0;
            cur_pos_reg  <= rd_pos;
            cur_tex_reg  <= rd_tex;
            cur_norm_reg <= rd_norm;
            cur_new_reg  <= 1'b0;
            cur_full_reg <= 1'b1;
        end
        else
        begin
            cur_idx_reg  <= cur_idx_reg;
            cur_pos_reg  <= cur_pos_reg;
            cur_tex_reg  <= cur_tex_reg;
            cur_norm_reg <= cur_norm_reg;
            cur_new_reg  <= cur_new_reg;
            cur_full_reg <= cur_full_reg;
        end
        if (cmd.emit_cur)
        begin
            if (corner_reg == '0)
            begin
                first_pos_reg  <= cur_pos_reg;
                first_tex_reg  <= cur_tex_reg;
                first_norm_reg <= cur_norm_reg;
            end
            last_pos_reg  <= cur_pos_reg;
            last_tex_reg  <= cur_tex_reg;
            last_norm_reg <= cur_norm_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_idx_next   = out_idx_reg;
        out_pos_next   = out_pos_reg;
        out_tex_next   = out_tex_reg;
        out_norm_next  = out_norm_reg;
        out_new_next   = out_new_reg;
        out_last_next  = out_last_reg;
        out_full_next  = out_full_reg;
        priority if (cmd.emit_first)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = first_idx_reg;
            out_pos_next   = first_pos_reg;
            out_tex_next   = first_tex_reg;
            out_norm_next  = first_norm_reg;
            out_new_next   = 1'b0;
            out_last_next  = 1'b0;
            out_full_next  = 1'b0;
        end
        else if (cmd.emit_last)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = last_idx_reg;
            out_pos_next   = last_pos_reg;
            out_tex_next   = last_tex_reg;
            out_norm_next  = last_norm_reg;
            out_new_next   = 1'b0;
            out_last_next  = 1'b0;
            out_full_next  = 1'b0;
        end
        else if (cmd.emit_cur)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = cur_idx_reg;
            out_pos_next   = cur_pos_reg;
            out_tex_next   = cur_tex_reg;
            out_norm_next  = cur_norm_reg;
            out_new_next   = cur_new_reg;
            out_last_next  = 1'b1;
            out_full_next  = cur_full_reg;
        end
        else
        begin
            // Hold a stalled result, drop a taken one
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_pos_reg  <= out_pos_next;
        out_tex_reg  <= out_tex_next;
        out_norm_reg <= out_norm_next;
        out_new_reg  <= out_new_next;
        out_last_reg <= out_last_next;
        out_full_reg <= out_full_next;
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign is_new       = out_new_reg;
    assign pos_value    = VAL_W'(out_pos_reg);
    assign tex_value    = VAL_W'(out_tex_reg);
    assign norm_value   = VAL_W'(out_norm_reg);
    assign run_last     = out_last_reg;
    assign table_full   = out_full_reg;

endmodule

`default_nettype wire

@@ sv/face_fan_vertex_dedup_core.sv @@
// Flow: with fewer than three table entries an accepted item is appended directly;
// otherwise stored entries are scanned in order until a match; a miss appends, or
// with a full table falls back to entry zero. A fan corner emits its two repeat
// results first. One item is taken at a time; the single vertex table read port
// compares one stored entry per cycle during a scan, and output stalls hold each emit.
// Reset: rst_n clears the fill count, fan indices, corner count and handshake state at
// once; the table memory is not cleared, since the fill count bounds every read.
`default_nettype none

module face_fan_vertex_dedup_core
    import fvd_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int REF_WIDTH   = DEF_REF_WIDTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Input item channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [REF_WIDTH-1:0] pos_ref,
    input  wire logic [REF_WIDTH-1:0] tex_ref,
    input  wire logic [REF_WIDTH-1:0] norm_ref,
    input  wire logic                 face_start,
    // Result item channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [IDX_W-1:0]          vertex_index,
    output logic                      is_new,
    output logic [VAL_W-1:0]          pos_value,
    output logic [VAL_W-1:0]          tex_value,
    output logic [VAL_W-1:0]          norm_value,
    output logic                      run_last,
    output logic                      table_full
);

    // The controller walks each corner through search, append or full-table
    // fallback, then up to three emit steps; the datapath holds the table,
    // the scan pointer and the fan registers.
    fvd_cmd_t  cmd;
    fvd_stat_t stat;

    fvd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fvd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .REF_WIDTH   (REF_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pos_ref      (pos_ref),
        .tex_ref      (tex_ref),
        .norm_ref     (norm_ref),
        .face_start   (face_start),
        .cmd          (cmd),
        .stat         (stat),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .vertex_index (vertex_index),
        .is_new       (is_new),
        .pos_value    (pos_value),
        .tex_value    (tex_value),
        .norm_value   (norm_value),
        .run_last     (run_last),
        .table_full   (table_full)
    );

`ifndef SYNTHESIS
    // One corner at a time: the cycle after an accepted item holds off the next
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous item in progress");

    // A full table never appends
    a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(table_full && is_new))
        else $error("table_full and is_new together");

    // Fan repeats carry no new or full flag
    a_repeat_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> (!is_new && !table_full))
        else $error("flags set on repeated fan index");

    // Full-table fallback names entry zero
    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_full) |-> (vertex_index == '0))
        else $error("full-table result with non-zero index");
`endif

endmodule

`default_nettype wire
